/* sv/mcpu_pkg.sv */
// shared types and constants for the microcoded cpu datapath
package mcpu_pkg;
   localparam int MEM_WORDS_DEF    = 32768;
   localparam int CONTROL_ROWS_DEF = 64;
   localparam int NUM_REGS_DEF     = 8;
   localparam int UW               = 35;
   localparam logic [5:0] START_ROW = 6'd18;
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_UCODE = 2'd1;
   localparam logic [1:0] ACT_MEM   = 2'd2;
   localparam logic [1:0] ACT_START = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic [5:0]  ucode_row;
      logic [34:0] ucode_word;
      logic [14:0] mem_word_addr;
      logic [15:0] mem_word;
      logic [2:0]  reg_select;
   } req_type;

   typedef struct packed {
      logic [15:0] pc_value;
      logic [15:0] ir_value;
      logic [15:0] bus_value;
      logic [15:0] mar_value;
      logic [15:0] mdr_value;
      logic [2:0]  cond_codes;
      logic [5:0]  micro_state;
      logic        mem_ready;
      logic        halted;
      logic [15:0] reg_value;
   } rsp_type;
endpackage

/* sv/mcpu_req_if.sv */
// request channel interface
interface mcpu_req_if;
   logic valid;
   logic ready;
   mcpu_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* sv/mcpu_rsp_if.sv */
// response channel interface
interface mcpu_rsp_if;
   logic valid;
   logic ready;
   mcpu_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* sv/microcoded_16bit_cpu_datapath_top.sv */
// top level of the microcoded 16-bit cpu datapath
//
// req carries one item: a tick, a control row write, a memory word write or
// a start. rsp returns one item per request with the architectural state
// after that item. csr_we/csr_wdata load the start pc, used by a start item.
// Items are taken back to back while rsp drains and no clearing pass runs.
// The control store and main memory are synchronous memories read ahead into
// registers: a tick brings the next control row into the micro word register
// by reading row j, or the opcode row when u[34] is set, into a registered
// copy, so the stage holding the micro word is refreshed after each tick or
// start item. A memory access needs five ticks; the word is prefetched from
// the MAR address on the earlier ticks, with forwarding of memory writes.
// After reset a clearing pass zeroes main memory; no item is accepted during
// it. The result sits in an output register; the block accepts a new item
// only if the output register is free or drains in the same cycle.
module microcoded_16bit_cpu_datapath_top #(
   parameter int MEM_WORDS = mcpu_pkg::MEM_WORDS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   mcpu_req_if.sink     req,
   mcpu_rsp_if.source   rsp,
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata
);
   import mcpu_pkg::*;
   localparam int AW = $clog2(MEM_WORDS);

   logic [UW-1:0] cstore [0:63];
   logic [15:0]   mem [0:MEM_WORDS-1];
   logic [15:0]   rf_ff [0:7];
   logic [15:0]   pc_ff, ir_ff, mar_ff, mdr_ff, spc_ff;
   logic [2:0]    nzp_ff, wcnt_ff;
   logic          ben_ff, rdy_ff;
   logic [UW-1:0] uw_ff;
   logic [5:0]    st_ff;
   logic          clr_ff;
   logic [AW:0]   clr_cnt_ff;
   logic          ov_ff;
   rsp_type       out_ff;
   logic [15:0]   mrd_ff;
   logic [UW-1:0] crd_ff;

   logic go, tick, u_act;
   logic [UW-1:0] u;
   logic [5:0] j, row;
   logic [15:0] a, b, alu, sr, shf, off, base, adr, mrm, bus, nmdr, w, wnew;
   logic [3:0] amt;
   logic [2:0] nwcnt, dr;
   logic nrdy, acc, mwe;
   logic [AW-1:0] idx;

   assign req.ready = !clr_ff && (!ov_ff || rsp.ready);
   assign go = req.valid && req.ready;
   assign tick = go && req.payload.action == ACT_TICK && pc_ff != 16'd0;
   assign u = uw_ff;
   assign rsp.valid = ov_ff;
   assign rsp.payload = out_ff;
   assign idx = mar_ff[AW:1];

   always_comb begin
      j = u[31:26];
      case (u[33:32])
         2'd1: j[1] = j[1] | rdy_ff;
         2'd2: j[2] = j[2] | ben_ff;
         2'd3: j[0] = j[0] | ir_ff[11];
         default: j = u[31:26];
      endcase
      row = u[34] ? {2'b00, ir_ff[15:12]} : j;
      a = rf_ff[u[10] ? ir_ff[8:6] : ir_ff[11:9]];
      b = ir_ff[5] ? {{11{ir_ff[4]}}, ir_ff[4:0]} : rf_ff[ir_ff[2:0]];
      case (u[5:4])
         2'd0: alu = a + b;
         2'd1: alu = a & b;
         2'd2: alu = a ^ b;
         default: alu = a;
      endcase
      sr = rf_ff[ir_ff[8:6]];
      amt = ir_ff[3:0];
      case (ir_ff[5:4])
         2'd0: shf = sr << amt;
         2'd1: shf = sr >> amt;
         2'd2: shf = 16'd0;
         default: shf = 16'($signed(sr) >>> amt);
      endcase
      case (u[8:7])
         2'd0: off = 16'd0;
         2'd1: off = {{10{ir_ff[5]}}, ir_ff[5:0]};
         2'd2: off = {{7{ir_ff[8]}}, ir_ff[8:0]};
         default: off = {{5{ir_ff[10]}}, ir_ff[10:0]};
      endcase
      if (u[0]) off = {off[14:0], 1'b0};
      base = u[9] ? sr : pc_ff;
      adr = off + base;
      mrm = u[6] ? adr : {7'd0, ir_ff[7:0], 1'b0};
      bus = (u[18] ? pc_ff : 16'd0) + (u[17] ? mdr_ff : 16'd0)
          + (u[16] ? alu : 16'd0) + (u[15] ? mrm : 16'd0)
          + (u[14] ? shf : 16'd0);
      nwcnt = wcnt_ff;
      nrdy = 1'b0;
      nmdr = mdr_ff;
      acc = 1'b0;
      w = mrd_ff;
      wnew = mrd_ff;
      if (u[3]) begin
         nwcnt = wcnt_ff + 3'd1;
         if (nwcnt == 3'd4) nrdy = 1'b1;
         else if (nwcnt >= 3'd5) begin
            acc = 1'b1;
            nwcnt = 3'd0;
            if (u[1]) wnew = mdr_ff;
            else if (mar_ff[0]) wnew = {mdr_ff[7:0], w[7:0]};
            else wnew = {w[15:8], mdr_ff[7:0]};
            if (!u[2]) begin
               if (u[1]) nmdr = w;
               else nmdr = mar_ff[0] ? {{8{w[15]}}, w[15:8]}
                                     : {{8{w[7]}}, w[7:0]};
            end
         end
      end else if (u[24]) nmdr = bus;
      dr = u[11] ? 3'd7 : ir_ff[11:9];
      u_act = go && req.payload.action == ACT_UCODE;
      mwe = tick && acc && u[2];
   end

   // memories: clearing pass, memory word writes and control row writes
   always_ff @(posedge clock) begin
      if (clr_ff) mem[clr_cnt_ff[AW-1:0]] <= 16'd0;
      else if (go && req.payload.action == ACT_MEM)
         mem[req.payload.mem_word_addr[AW-1:0]] <= req.payload.mem_word;
      else if (mwe) mem[idx] <= wnew;
      if (u_act) cstore[req.payload.ucode_row] <= req.payload.ucode_word;
   end

   // combinational forwarding keeps mrd_ff equal to mem[mar>>1]
   logic [15:0] nmar;
   logic [AW-1:0] nidx;
   assign nmar = (tick && u[25]) ? bus : mar_ff;
   assign nidx = nmar[AW:1];
   always_ff @(posedge clock) begin
      if (go && req.payload.action == ACT_MEM
          && req.payload.mem_word_addr[AW-1:0] == nidx)
         mrd_ff <= req.payload.mem_word;
      else if (mwe && idx == nidx) mrd_ff <= wnew;
      else mrd_ff <= mem[nidx];
   end

   logic [5:0] crow;
   assign crow = (go && req.payload.action == ACT_START) ? START_ROW : row;
   always_ff @(posedge clock) begin
      if (u_act && req.payload.ucode_row == crow) crd_ff <= req.payload.ucode_word;
      else crd_ff <= cstore[crow];
   end

   logic pend_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1;
         clr_cnt_ff <= '0;
         pc_ff <= '0; ir_ff <= '0; mar_ff <= '0; mdr_ff <= '0;
         nzp_ff <= 3'b010; ben_ff <= 1'b0; rdy_ff <= 1'b0;
         st_ff <= START_ROW; wcnt_ff <= '0; spc_ff <= '0; ov_ff <= 1'b0;
         pend_ff <= 1'b0;
         for (int i = 0; i < 8; i++) rf_ff[i] <= '0;
      end else begin
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == (AW+1)'(MEM_WORDS - 1)) clr_ff <= 1'b0;
         end
         if (csr_we) spc_ff <= csr_wdata;
         if (go) ov_ff <= 1'b1;
         else if (rsp.ready) ov_ff <= 1'b0;
         pend_ff <= tick || (go && req.payload.action == ACT_START);
         if (go) begin
            if (tick) begin
               if (u[22]) ben_ff <= (ir_ff[11] & nzp_ff[2]) |
                                    (ir_ff[10] & nzp_ff[1]) | (ir_ff[9] & nzp_ff[0]);
               if (u[20]) nzp_ff <= (bus == 16'd0) ? 3'b010 :
                                    (bus[15] ? 3'b100 : 3'b001);
               if (u[21]) rf_ff[dr] <= bus;
               if (u[19]) begin
                  case (u[13:12])
                     2'd0: pc_ff <= pc_ff + 16'd2;
                     2'd1: pc_ff <= bus;
                     default: pc_ff <= adr;
                  endcase
               end
               if (u[25]) mar_ff <= bus;
               if (u[23]) ir_ff <= bus;
               mdr_ff <= nmdr;
               rdy_ff <= nrdy;
               wcnt_ff <= nwcnt;
               st_ff <= row;
            end else if (req.payload.action == ACT_START) begin
               pc_ff <= spc_ff;
               nzp_ff <= 3'b010;
               st_ff <= START_ROW;
            end
         end
      end
   end

   // micro word register holds the control row of the current state
   logic [UW-1:0] uhold_ff;
   always_ff @(posedge clock) begin
      if (reset) uhold_ff <= '0;
      else if (pend_ff) uhold_ff <= crd_ff;
   end
   assign uw_ff = pend_ff ? crd_ff : uhold_ff;

   always_ff @(posedge clock) begin
      if (go) begin
         out_ff.pc_value <= (req.payload.action == ACT_START) ? spc_ff
                          : (tick && u[19]) ? (u[13:12] == 2'd0 ? pc_ff + 16'd2
                          : (u[13:12] == 2'd1 ? bus : adr)) : pc_ff;
         out_ff.ir_value <= (tick && u[23]) ? bus : ir_ff;
         out_ff.bus_value <= tick ? bus : 16'd0;
         out_ff.mar_value <= (tick && u[25]) ? bus : mar_ff;
         out_ff.mdr_value <= tick ? nmdr : mdr_ff;
         out_ff.cond_codes <= (req.payload.action == ACT_START) ? 3'b010
                            : (tick && u[20]) ? ((bus == 16'd0) ? 3'b010
                            : (bus[15] ? 3'b100 : 3'b001)) : nzp_ff;
         out_ff.micro_state <= (req.payload.action == ACT_START) ? START_ROW
                             : tick ? row : st_ff;
         out_ff.mem_ready <= tick ? nrdy : rdy_ff;
         out_ff.halted <= req.payload.action == ACT_TICK && pc_ff == 16'd0;
         out_ff.reg_value <= (tick && u[21] && dr == req.payload.reg_select) ? bus
                           : rf_ff[req.payload.reg_select];
      end
   end
endmodule
